// ===== rtl/tcw_pkg.sv =====
`timescale 1ns / 1ps
// shared constants, codes and types for the text console writer
// no dependencies

package tcw_pkg;

  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = COLUMNS * ROWS;

  localparam int ADDR_W = $clog2(CELLS);
  localparam int COL_W  = (COLUMNS > 2) ? $clog2(COLUMNS) : 1;
  localparam int ROW_W  = (ROWS > 2) ? $clog2(ROWS) : 1;

  // field widths of the item channels
  localparam int CMD_W    = 3;
  localparam int BYTE_W   = 8;
  localparam int OCOL_W   = 7;
  localparam int OROW_W   = 5;
  localparam int OADDR_W  = 11;
  localparam int CELL_W   = 16;

  localparam logic [BYTE_W-1:0] RESET_ATTR = 8'h07;
  localparam logic [BYTE_W-1:0] BLANK_CHAR = 8'h20;
  localparam logic [BYTE_W-1:0] NL_CHAR    = 8'h0a;
  localparam logic [BYTE_W-1:0] CR_CHAR    = 8'h0d;
  localparam logic [BYTE_W-1:0] BS_CHAR    = 8'h08;

  localparam logic [CMD_W-1:0] CMD_PUT    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_SETCUR = 3'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_SCROLL = 3'd3;
  localparam logic [CMD_W-1:0] CMD_READ   = 3'd4;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [CELL_W-1:0] cell_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLEAR,
    ST_SCROLL,
    ST_RESULT
  } state_t;

endpackage

// ===== rtl/tcw_if.sv =====
`timescale 1ns / 1ps
// valid/ready channel interfaces for the text console writer
// depends on tcw_pkg

interface tcw_in_if;
  import tcw_pkg::*;
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [BYTE_W-1:0] char_code;
  logic [BYTE_W-1:0] column;
  logic [BYTE_W-1:0] row;
  modport source (output valid, command, char_code, column, row, input ready);
  modport sink (input valid, command, char_code, column, row, output ready);
endinterface

interface tcw_out_if;
  import tcw_pkg::*;
  logic               valid;
  logic               ready;
  logic               accepted;
  logic [OCOL_W-1:0]  cursor_col;
  logic [OROW_W-1:0]  cursor_row;
  logic [OADDR_W-1:0] cursor_address;
  logic [CELL_W-1:0]  cell_data;
  modport source (output valid, accepted, cursor_col, cursor_row, cursor_address, cell_data,
                  input ready);
  modport sink (input valid, accepted, cursor_col, cursor_row, cursor_address, cell_data,
                output ready);
endinterface

interface tcw_cfg_if;
  import tcw_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] attribute;
  modport source (output valid, attribute, input ready);
  modport sink (input valid, attribute, output ready);
endinterface

// ===== rtl/text_console_writer_core.sv =====
`timescale 1ns / 1ps
// text console writer: cell memory, cursor and command sequencer
// depends on tcw_pkg and the channel interfaces in tcw_if

// A text-mode console engine: an 80x25 store of attribute/character words in one
// memory with one write and one registered read port, plus a cursor. After reset a
// clearing pass writes every cell once and no item is accepted until it ends; attribute
// writes are taken at any time. For put char, set cursor, read cell and rejected commands,
// the command acts in the cycle the item is accepted and the result is loaded in the
// result state that follows, once the output register is free. Clear, scroll, and a
// newline or wrap on the last row sweep the whole memory through its single write port,
// one cell a cycle, before the result state. The result waits in an output register, so a
// stalled output holds the engine only when the next result is due.

module text_console_writer_core (
  input  logic       clk,
  input  logic       rst_n,
  tcw_in_if.sink     in_ch,
  tcw_out_if.source  out_ch,
  tcw_cfg_if.sink    cfg_ch
);
  import tcw_pkg::*;

  localparam addr_t LAST_CELL  = addr_t'(CELLS - 1);
  localparam addr_t COPY_CELLS = addr_t'(CELLS - COLUMNS);
  localparam addr_t COLS_A     = addr_t'(COLUMNS);

  state_t state_r, state_nxt;

  cell_t mem [CELLS];
  cell_t rd_data_r;

  logic [BYTE_W-1:0] attr_r;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  addr_t             sweep_r, sweep_nxt;

  // delayed write of the scroll copy
  logic  wpend_r, wpend_nxt;
  addr_t wpend_addr_r, wpend_addr_nxt;
  logic  wpend_copy_r, wpend_copy_nxt;

  logic acc_r, acc_nxt;
  logic is_read_r, is_read_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic               out_acc_r;
  logic [OCOL_W-1:0]  out_col_r;
  logic [OROW_W-1:0]  out_row_r;
  logic [OADDR_W-1:0] out_addr_r;
  cell_t              out_cell_r;

  logic  wr_en, rd_en;
  addr_t wr_addr, rd_addr;
  cell_t wr_data;
  logic  go_scroll, go_clear, load_out;

  logic  in_fire;
  cell_t blank;
  addr_t cur_addr;
  logic [COL_W-1:0] clamp_col;
  logic [ROW_W-1:0] clamp_row;
  addr_t clamp_addr;
  logic  last_col, last_row;

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  assign blank     = {attr_r, BLANK_CHAR};
  assign cur_addr  = addr_t'(addr_t'(row_r) * COLS_A) + addr_t'(col_r);
  assign clamp_col = (in_ch.column >= BYTE_W'(COLUMNS)) ? COL_W'(COLUMNS - 1)
                                                        : COL_W'(in_ch.column);
  assign clamp_row = (in_ch.row >= BYTE_W'(ROWS)) ? ROW_W'(ROWS - 1)
                                                  : ROW_W'(in_ch.row);
  assign clamp_addr = addr_t'(addr_t'(clamp_row) * COLS_A) + addr_t'(clamp_col);
  assign last_col  = (col_r == COL_W'(COLUMNS - 1));
  assign last_row  = (row_r == ROW_W'(ROWS - 1));
  assign load_out  = (state_r == ST_RESULT) && (!out_valid_r || out_ch.ready);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_INIT: begin
        if (sweep_r == LAST_CELL) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_fire) begin
          if (go_clear) state_nxt = ST_CLEAR;
          else if (go_scroll) state_nxt = ST_SCROLL;
          else state_nxt = ST_RESULT;
        end
      end
      ST_CLEAR, ST_SCROLL: begin
        if (sweep_r == LAST_CELL) state_nxt = ST_RESULT;
      end
      ST_RESULT: begin
        if (load_out) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_INIT;
    endcase
  end

  // command decode, memory control and cursor update
  always_comb begin
    wr_en          = 1'b0;
    wr_addr        = sweep_r;
    wr_data        = blank;
    rd_en          = 1'b0;
    rd_addr        = clamp_addr;
    col_nxt        = col_r;
    row_nxt        = row_r;
    sweep_nxt      = sweep_r;
    wpend_nxt      = 1'b0;
    wpend_addr_nxt = sweep_r;
    wpend_copy_nxt = 1'b0;
    acc_nxt        = acc_r;
    is_read_nxt    = is_read_r;
    go_scroll      = 1'b0;
    go_clear       = 1'b0;

    if (wpend_r) begin
      wr_en   = 1'b1;
      wr_addr = wpend_addr_r;
      wr_data = wpend_copy_r ? rd_data_r : blank;
    end

    case (state_r)
      ST_INIT: begin
        wr_en     = 1'b1;
        wr_addr   = sweep_r;
        wr_data   = {RESET_ATTR, BLANK_CHAR};
        sweep_nxt = (sweep_r == LAST_CELL) ? '0 : sweep_r + addr_t'(1);
      end
      ST_IDLE: begin
        if (in_fire) begin
          acc_nxt     = 1'b1;
          is_read_nxt = 1'b0;
          case (in_ch.command)
            CMD_PUT: begin
              if (in_ch.char_code == NL_CHAR) begin
                col_nxt = '0;
                if (last_row) go_scroll = 1'b1;
                else row_nxt = row_r + ROW_W'(1);
              end else if (in_ch.char_code == CR_CHAR) begin
                col_nxt = '0;
              end else if (in_ch.char_code == BS_CHAR) begin
                if (col_r != '0) begin
                  col_nxt = col_r - COL_W'(1);
                  wr_en   = 1'b1;
                  wr_addr = cur_addr - addr_t'(1);
                  wr_data = blank;
                end
              end else begin
                wr_en   = 1'b1;
                wr_addr = cur_addr;
                wr_data = {attr_r, in_ch.char_code};
                if (last_col) begin
                  col_nxt = '0;
                  if (last_row) go_scroll = 1'b1;
                  else row_nxt = row_r + ROW_W'(1);
                end else begin
                  col_nxt = col_r + COL_W'(1);
                end
              end
            end
            CMD_SETCUR: begin
              col_nxt = clamp_col;
              row_nxt = clamp_row;
            end
            CMD_CLEAR: begin
              go_clear = 1'b1;
              col_nxt  = '0;
              row_nxt  = '0;
            end
            CMD_SCROLL: go_scroll = 1'b1;
            CMD_READ: begin
              rd_en       = 1'b1;
              rd_addr     = clamp_addr;
              is_read_nxt = 1'b1;
            end
            default: acc_nxt = 1'b0;
          endcase
        end
      end
      ST_CLEAR: begin
        wr_en     = 1'b1;
        wr_addr   = sweep_r;
        wr_data   = blank;
        sweep_nxt = (sweep_r == LAST_CELL) ? '0 : sweep_r + addr_t'(1);
      end
      ST_SCROLL: begin
        // read the cell one row below (blank on the last row), write it back in the next cycle
        rd_en          = (sweep_r < COPY_CELLS);
        rd_addr        = sweep_r + COLS_A;
        wpend_nxt      = 1'b1;
        wpend_addr_nxt = sweep_r;
        wpend_copy_nxt = (sweep_r < COPY_CELLS);
        sweep_nxt      = (sweep_r == LAST_CELL) ? '0 : sweep_r + addr_t'(1);
      end
      ST_RESULT: begin
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) out_valid_nxt = 1'b1;
    else if (out_ch.ready) out_valid_nxt = 1'b0;
  end

  // cell memory
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      attr_r      <= RESET_ATTR;
      col_r       <= '0;
      row_r       <= '0;
      sweep_r     <= '0;
      wpend_r     <= 1'b0;
      out_valid_r <= 1'b0;
      acc_r       <= 1'b0;
      is_read_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      sweep_r     <= sweep_nxt;
      wpend_r     <= wpend_nxt;
      out_valid_r <= out_valid_nxt;
      acc_r       <= acc_nxt;
      is_read_r   <= is_read_nxt;
      if (cfg_ch.valid && cfg_ch.ready) attr_r <= cfg_ch.attribute;
    end
  end

  always_ff @(posedge clk) begin
    wpend_addr_r <= wpend_addr_nxt;
    wpend_copy_r <= wpend_copy_nxt;
    if (load_out) begin
      out_acc_r  <= acc_r;
      out_col_r  <= OCOL_W'(col_r);
      out_row_r  <= OROW_W'(row_r);
      out_addr_r <= OADDR_W'(cur_addr);
      out_cell_r <= is_read_r ? rd_data_r : '0;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.accepted       = out_acc_r;
  assign out_ch.cursor_col     = out_col_r;
  assign out_ch.cursor_row     = out_row_r;
  assign out_ch.cursor_address = out_addr_r;
  assign out_ch.cell_data      = out_cell_r;

endmodule
